### design/i64dm_pkg.sv
// Shared constants and command codes for the 64-bit divide/modulo pipeline.
`default_nettype none
package i64dm_pkg;

   localparam int DEFAULT_WIDTH = 64;
   localparam int DATA_BITS     = 64;
   localparam int CMD_BITS      = 2;

   localparam logic [CMD_BITS-1:0] CMD_UDIV = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_UREM = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SDIV = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_SREM = 2'd3;

endpackage
`default_nettype wire

### design/int64_divide_modulo.sv
// Pipelined restoring divider: signed/unsigned quotient and remainder.
//
// Use: send one word on the req_ channel: req_tuser carries the command
// (unsigned divide, unsigned remainder, signed divide, signed remainder),
// req_tdata carries dividend and divisor. One result word comes back on the
// rsp_ channel per request, in request order, holding the quotient or the
// remainder zero-extended to 64 bits. A zero divisor returns 0.
// Pipeline: from acceptance to rsp_tvalid a word passes these stages in order:
// one stage takes operand magnitudes, one stage per bit runs a
// compare-subtract round, one stage applies the sign and drives rsp_tdata.
// Throughput: one word per cycle while rsp_tready is high; each round has its own subtractor.
// When rsp_tready is low the output stage holds its word; earlier stages
// keep moving into empty slots, and req_tready drops only once every stage
// from the input to the output is full. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline then accepts a word at once.
`default_nettype none
module int64_divide_modulo #(
   parameter int WIDTH = i64dm_pkg::DEFAULT_WIDTH
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         req_tvalid,
   output logic                                              req_tready,
   input  wire logic [2*i64dm_pkg::DATA_BITS-1:0]            req_tdata,  // divisor (upper half), dividend (lower half)
   input  wire logic [i64dm_pkg::CMD_BITS-1:0]               req_tuser,  // command
   output logic                                              rsp_tvalid,
   input  wire logic                                         rsp_tready,
   output logic [i64dm_pkg::DATA_BITS-1:0]                   rsp_tdata   // result
);
   import i64dm_pkg::*;

   localparam int LAST = WIDTH + 1;

   logic [LAST:0]      valid_ff;
   logic [LAST:0]      ready;

   logic [WIDTH-1:0]   rem_ff   [0:WIDTH];
   logic [WIDTH-1:0]   numq_ff  [0:WIDTH];
   logic [WIDTH-1:0]   den_ff   [0:WIDTH];
   logic               rem_sel_ff [0:WIDTH];
   logic               negate_ff  [0:WIDTH];
   logic               zero_ff    [0:WIDTH];

   logic [WIDTH-1:0]   rem_in   [1:WIDTH];
   logic [WIDTH-1:0]   numq_in  [1:WIDTH];
   logic [WIDTH-1:0]   num_in;
   logic [WIDTH-1:0]   den_in;
   logic               rem_sel_in;
   logic               negate_in;
   logic               zero_in;

   logic [WIDTH-1:0]   result_ff;
   logic [WIDTH-1:0]   result_in;

   logic [WIDTH-1:0]   op_a;
   logic [WIDTH-1:0]   op_b;
   logic               is_signed;
   logic               neg_a;
   logic               neg_b;
   logic [WIDTH:0]     trial [1:WIDTH];
   logic [WIDTH-1:0]   pick;

   always_comb begin
      ready[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int s = LAST - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = DATA_BITS'(result_ff);

   // take magnitudes and sign handling flags
   always_comb begin
      op_a       = req_tdata[WIDTH-1:0];
      op_b       = req_tdata[DATA_BITS +: WIDTH];
      is_signed  = (req_tuser == CMD_SDIV) || (req_tuser == CMD_SREM);
      neg_a      = is_signed && op_a[WIDTH-1];
      neg_b      = is_signed && op_b[WIDTH-1];
      num_in     = neg_a ? (WIDTH'(0) - op_a) : op_a;
      den_in     = neg_b ? (WIDTH'(0) - op_b) : op_b;
      zero_in    = (op_b == '0);
      rem_sel_in = (req_tuser == CMD_UREM) || (req_tuser == CMD_SREM);
      case (req_tuser)
         CMD_SDIV: negate_in = neg_a ^ neg_b;
         CMD_SREM: negate_in = neg_a;
         default:  negate_in = 1'b0;
      endcase
   end

   // one compare-subtract round per stage
   always_comb begin
      for (int k = 1; k <= WIDTH; k++) begin
         trial[k] = {rem_ff[k-1], numq_ff[k-1][WIDTH-1]} - {1'b0, den_ff[k-1]};
         if (!trial[k][WIDTH]) begin
            rem_in[k] = trial[k][WIDTH-1:0];
         end else begin
            rem_in[k] = {rem_ff[k-1][WIDTH-2:0], numq_ff[k-1][WIDTH-1]};
         end
         numq_in[k] = {numq_ff[k-1][WIDTH-2:0], !trial[k][WIDTH]};
      end
   end

   always_comb begin
      pick = rem_sel_ff[WIDTH] ? rem_ff[WIDTH] : numq_ff[WIDTH];
      if (zero_ff[WIDTH]) begin
         result_in = '0;
      end else if (negate_ff[WIDTH]) begin
         result_in = WIDTH'(0) - pick;
      end else begin
         result_in = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int s = 1; s <= LAST; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         rem_ff[0]     <= '0;
         numq_ff[0]    <= num_in;
         den_ff[0]     <= den_in;
         rem_sel_ff[0] <= rem_sel_in;
         negate_ff[0]  <= negate_in;
         zero_ff[0]    <= zero_in;
      end
      for (int s = 1; s <= WIDTH; s++) begin
         if (ready[s]) begin
            rem_ff[s]     <= rem_in[s];
            numq_ff[s]    <= numq_in[s];
            den_ff[s]     <= den_ff[s-1];
            rem_sel_ff[s] <= rem_sel_ff[s-1];
            negate_ff[s]  <= negate_ff[s-1];
            zero_ff[s]    <= zero_ff[s-1];
         end
      end
      if (ready[LAST]) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire
